>>> src/assert_macros.svh
// Assertion macros shared by the lru size cache RTL.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> src/lsc_pkg.sv
// Package for the lru size cache: widths, word types and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package lsc_pkg;
	localparam int SIZE_W = 63;
	localparam int KEYF_W = 64;
	localparam int LIMIT_W = 7;

	// floor(x/5) as (x*DIV5_MUL) >> DIV5_SHIFT, exact for x below 2^16
	localparam int unsigned DIV5_MUL = 52429;
	localparam int DIV5_SHIFT = 18;

	typedef struct packed {
		logic              mode;
		logic [KEYF_W-1:0] key_tag;
		logic [SIZE_W-1:0] file_size;
	} lsc_req_t;

	typedef struct packed {
		logic              hit;
		logic [SIZE_W-1:0] size_out;
	} lsc_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RANK,
		ST_DONE
	} lsc_state_t;
endpackage

>>> src/lsc_stream_if.sv
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface lsc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/lsc_ram.sv
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module lsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> src/lru_size_cache_batch_evict.sv
// Top level of the lru size cache with batch eviction.
// Depends on lsc_pkg, lsc_stream_if, lsc_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Fully associative size cache, LRU order, one word out per word in.
// A sequencer walks every slot twice through one shared compare unit:
// pass 1 (SCAN) reads key/rank RAMs to find the hit slot and its rank,
// pass 2 (RANK) rewrites ranks (refresh, age, or batch evict by rank).
// Each pass reads one slot per cycle, with an extra walk step for the
// registered RAM read; DONE then commits key, size and new rank and
// registers the output word. With a limit of zero the walk is skipped and
// the sequencer goes from IDLE straight to DONE. Valid bits live in flops
// and clear at reset, so no clearing pass is needed. The output word is
// registered; a new word is taken the cycle after it has been drained, so
// no new input word is taken while an output word waits.
module lru_size_cache_batch_evict #(
	parameter int CAPACITY = 64,
	parameter int KEY_WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lsc_pkg::LIMIT_W-1:0]  cfg_wdata,
	lsc_stream_if.sink                   in_ch,
	lsc_stream_if.source                 out_ch
);
	import lsc_pkg::*;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	lsc_state_t st_q, st_d;
	logic [LIMIT_W-1:0] max_q;
	logic [CAPACITY-1:0] vld_q;
	logic [CW-1:0] occ_q;
	logic mode_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [SIZE_W-1:0] fsz_q;
	logic [AW:0] idx_q;          // slot walk counter, extra bit for read latency
	logic found_q;
	logic [AW-1:0] hslot_q;
	logic [AW-1:0] hrank_q;
	logic [AW-1:0] free_q;
	logic free_ok_q;
	logic insert_q, evict_q, all_q;
	logic [CW-1:0] keep_q;
	logic ovld_q, ohit_q;
	logic [SIZE_W-1:0] osz_q;

	// effective limit and batch size; limit/5 by reciprocal multiply
	logic [CW-1:0] lim;
	logic [CW-1:0] batch;
	logic [31:0] batch_prod;
	always_comb begin
		if (32'(max_q) > CAPACITY) lim = CW'(CAPACITY);
		else lim = CW'(max_q);
		batch_prod = 32'(lim) * 32'(DIV5_MUL);
		batch = CW'(batch_prod >> DIV5_SHIFT);
		if (batch == '0) batch = CW'(1);
	end

	// RAM ports
	logic [AW-1:0] ra;
	logic key_we, sz_we, rk_we;
	logic [AW-1:0] rk_wa;
	logic [AW-1:0] rk_wd;
	logic [KEY_WIDTH-1:0] key_rd;
	logic [SIZE_W-1:0] sz_rd;
	logic [AW-1:0] rk_rd;
	logic [AW-1:0] rs;           // slot whose read data is present now
	logic rd_live;

	assign rd_live = (idx_q != '0);
	assign rs = AW'(idx_q - 1'b1);

	always_comb begin
		ra = idx_q[AW-1:0];
		if (st_q == ST_DONE) ra = found_q ? hslot_q : free_q;
	end

	lsc_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key (
		.clk(clk), .we(key_we), .waddr(ra), .wdata(key_q), .raddr(ra), .rdata(key_rd));
	lsc_ram #(.WIDTH(SIZE_W), .DEPTH(CAPACITY)) u_size (
		.clk(clk), .we(sz_we), .waddr(ra), .wdata(fsz_q), .raddr(ra), .rdata(sz_rd));
	// rank pass reads slot idx while writing back slot idx-1
	lsc_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_rank (
		.clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd), .raddr(ra), .rdata(rk_rd));

	logic walk_end;
	assign walk_end = (idx_q == (AW+1)'(CAPACITY));

	// shared compare unit: one slot per cycle
	logic cur_v, key_eq;
	assign cur_v = vld_q[rs];
	assign key_eq = (key_rd == key_q);

	// rank pass decisions for slot rs; new entry gets rank 0 in DONE
	logic rk_kill;
	always_comb begin
		rk_we = 1'b0;
		rk_wa = rs;
		rk_wd = rk_rd;
		rk_kill = 1'b0;
		if (st_q == ST_RANK && rd_live && cur_v) begin
			if (found_q) begin
				if (rs == hslot_q) begin
					rk_we = 1'b1; rk_wd = '0;
				end else if (rk_rd < hrank_q) begin
					rk_we = 1'b1; rk_wd = rk_rd + 1'b1;
				end
			end else if (insert_q) begin
				if (all_q || (evict_q && CW'(rk_rd) >= keep_q)) begin
					rk_kill = 1'b1;
				end else begin
					rk_we = 1'b1; rk_wd = rk_rd + 1'b1;
				end
			end
		end else if (st_q == ST_DONE && lim != '0 && insert_q && free_ok_q) begin
			rk_we = 1'b1;
			rk_wa = free_q;
			rk_wd = '0;
		end
	end

	logic acc;
	assign acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == ST_IDLE) && !ovld_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (acc) st_d = (lim == '0) ? ST_DONE : ST_SCAN;
			ST_SCAN: if (walk_end) st_d = ST_RANK;
			ST_RANK: if (walk_end) st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// key and size RAM writes happen in DONE
	always_comb begin
		key_we = 1'b0;
		sz_we = 1'b0;
		if (st_q == ST_DONE && lim != '0 && mode_q) begin
			if (found_q) sz_we = 1'b1;
			else if (free_ok_q) begin
				key_we = 1'b1; sz_we = 1'b1;
			end
		end
	end

	// free slot after eviction, resolved during RANK
	logic slot_free;
	assign slot_free = !cur_v || rk_kill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			max_q <= LIMIT_W'(64);
			vld_q <= '0;
			occ_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			free_ok_q <= 1'b0;
			insert_q <= 1'b0;
			evict_q <= 1'b0;
			all_q <= 1'b0;
			keep_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) max_q <= cfg_wdata;
			if (out_ch.valid && out_ch.ready) ovld_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					idx_q <= '0;
					found_q <= 1'b0;
					free_ok_q <= 1'b0;
				end
				ST_SCAN: begin
					if (rd_live && cur_v && key_eq && !found_q) found_q <= 1'b1;
					if (walk_end) begin
						idx_q <= '0;
						insert_q <= mode_q && !(found_q || (cur_v && key_eq));
						evict_q <= (occ_q >= lim) && (occ_q != '0);
						all_q <= (occ_q >= lim) && (batch >= occ_q);
						keep_q <= occ_q - batch;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_RANK: begin
					if (rk_kill) vld_q[rs] <= 1'b0;
					if (rd_live && insert_q && !free_ok_q && slot_free) free_ok_q <= 1'b1;
					if (walk_end) idx_q <= '0;
					else idx_q <= idx_q + 1'b1;
					if (walk_end && insert_q) begin
						if (all_q) occ_q <= '0;
						else if (evict_q) occ_q <= keep_q;
					end
				end
				ST_DONE: begin
					ovld_q <= 1'b1;
					if (lim != '0 && insert_q && free_ok_q) begin
						vld_q[free_q] <= 1'b1;
						occ_q <= occ_q + 1'b1;
					end
					insert_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= in_ch.data.mode;
			key_q <= in_ch.data.key_tag[KEY_WIDTH-1:0];
			fsz_q <= in_ch.data.file_size;
		end
		if (st_q == ST_SCAN && rd_live && cur_v && key_eq && !found_q) begin
			hslot_q <= rs;
			hrank_q <= rk_rd;
			osz_q <= sz_rd;
		end
		if (st_q == ST_RANK && rd_live && insert_q && !free_ok_q && slot_free)
			free_q <= rs;
		if (st_q == ST_DONE) begin
			ohit_q <= (lim != '0) && found_q;
			if (!((lim != '0) && found_q && !mode_q)) osz_q <= '0;
		end
	end

	assign out_ch.valid = ovld_q;
	assign out_ch.data.hit = ohit_q;
	assign out_ch.data.size_out = osz_q;

	`ASSERT_NEVER(a_busy_ready, clk, arst_n, in_ch.ready && st_q != ST_IDLE)
	`ASSERT_IMPL(a_done_out, clk, arst_n, st_q == ST_DONE |=> out_ch.valid)
	`ASSERT_NEVER(a_occ_cap, clk, arst_n, 32'(occ_q) > CAPACITY)
	`ASSERT_IMPL(a_hit_mode, clk, arst_n,
		(out_ch.valid && !out_ch.data.hit) |-> out_ch.data.size_out == '0)
endmodule
